// ----- design/assert_macros.svh -----
// Assertion macros shared by the terminal cursor engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tte_pkg.sv -----
// Types and fixed constants of the text terminal cursor engine.
// Depends on nothing; used by every module of the block.
package tte_pkg;

    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Drawing command codes.
    localparam logic [1:0] OP_GLYPH  = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;

    // Control characters.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 3'd4;

    // Register reset values.
    localparam logic [7:0]         RST_COLS = 8'd80;
    localparam logic [6:0]         RST_ROWS = 7'd25;
    localparam logic [COLOR_W-1:0] RST_FG   = 24'hE8E8E8;
    localparam logic [COLOR_W-1:0] RST_BG   = 24'h1A1A24;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [7:0]         glyph;
        logic [COLOR_W-1:0] fg_out;
        logic [COLOR_W-1:0] bg_out;
        logic               last;
    } t_out_item;

    // Operands of the shared multiply-add unit: base + a * b.
    typedef struct packed {
        logic [COORD_W-1:0] base;
        logic [7:0]         a;
        logic [5:0]         b;
    } t_mac_req;

endpackage

// ----- design/tte_mac.sv -----
// Shared multiply-add unit: registers base + a * b, kept to 12 bits.
// Depends on tte_pkg for the request struct and coordinate width.
module tte_mac (
    input  logic                        i_clk,
    input  logic                        i_start,
    input  tte_pkg::t_mac_req           i_req,
    output logic [tte_pkg::COORD_W-1:0] o_res
);

    logic [13:0]                 w_sum;
    logic [tte_pkg::COORD_W-1:0] r_res;

    assign w_sum = 14'(i_req.base) + (14'(i_req.a) * 14'(i_req.b));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res <= w_sum[tte_pkg::COORD_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/tte_obuf.sv -----
// Output register stage holding one drawing command until it is taken.
// Depends on tte_pkg for the result item type.
module tte_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tte_pkg::t_out_item i_data,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output tte_pkg::t_out_item o_data
);

    logic               r_valid;
    tte_pkg::t_out_item r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/text_terminal_cursor_engine.sv -----
// Text terminal cursor engine: cursor sequencer, config registers, output stage.
// Depends on tte_pkg, tte_mac, tte_obuf and assert_macros.svh.
// Each drawing command passes through the states MUL_A and MUL_B, one per multiply-add,
// and EMIT, which waits for the output register; an input that draws nothing never leaves
// IDLE. A new request is taken only in IDLE, once the previous one has drawn all its commands.
// Reset (synchronous, active low) homes the cursor and loads register defaults.
`include "assert_macros.svh"

module text_terminal_cursor_engine #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int LEFT_MARGIN  = 12,
    parameter int TOP_MARGIN   = 40,
    parameter int TAB_STOP     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel: one character or clear command per request.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tte_pkg::t_in_item             i_in_data,
    // Drawing command channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tte_pkg::t_out_item            o_out_data,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tte_pkg::COLOR_W-1:0]   i_cfg_data
);

    // The tab phase tracks cursor_col modulo TAB_STOP, so a tab never needs
    // a divider: it is kept up to date on every cursor move.
    localparam int PW = $clog2(TAB_STOP);
    localparam int LW = $clog2(TAB_STOP + 1);

    localparam logic [PW-1:0] PHASE_LAST = PW'(TAB_STOP - 1);
    localparam logic [LW-1:0] TAB_COUNT  = LW'(TAB_STOP);

    localparam logic [tte_pkg::COORD_W-1:0] LM = tte_pkg::COORD_W'(LEFT_MARGIN);
    localparam logic [tte_pkg::COORD_W-1:0] TM = tte_pkg::COORD_W'(TOP_MARGIN);
    localparam logic [tte_pkg::COORD_W-1:0] GW = tte_pkg::COORD_W'(GLYPH_WIDTH);
    localparam logic [tte_pkg::COORD_W-1:0] GH = tte_pkg::COORD_W'(GLYPH_HEIGHT);
    localparam logic [5:0] GW_M = 6'(GLYPH_WIDTH);
    localparam logic [5:0] GH_M = 6'(GLYPH_HEIGHT);

    // One-hot sequencer. MUL_A and MUL_B issue the two multiply-adds of a
    // command (x then y for a cell, width then height for the whole area);
    // EMIT waits for the output register and then decides what follows.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL_A = 4'b0010,
        S_MUL_B = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // Configuration registers.
    logic                        r_enable;
    logic [7:0]                  r_cols;
    logic [6:0]                  r_rows;
    logic [tte_pkg::COLOR_W-1:0] r_fg;
    logic [tte_pkg::COLOR_W-1:0] r_bg;

    // Cursor and sequencer state.
    t_state        r_state,  n_state;
    logic [7:0]    r_col,    n_col;
    logic [6:0]    r_row,    n_row;
    logic [PW-1:0] r_phase,  n_phase;
    logic [1:0]    r_op,     n_op;
    logic          r_area,   n_area;
    logic [7:0]    r_glyph,  n_glyph;
    logic [LW-1:0] r_left,   n_left;
    logic [tte_pkg::COORD_W-1:0] r_res_a, n_res_a;

    logic [7:0]                  w_cols_eff;
    logic [6:0]                  w_rows_eff;
    logic [8:0]                  w_col_inc;
    logic [7:0]                  w_row_inc;
    logic                        w_wrap;
    logic                        w_row_over;
    logic                        w_accept;
    logic                        w_mac_start;
    tte_pkg::t_mac_req           w_mac_req;
    logic [tte_pkg::COORD_W-1:0] w_mac_res;
    logic                        w_out_free;
    logic                        w_out_load;
    tte_pkg::t_out_item          w_out_item;

    // A size of zero behaves as one.
    assign w_cols_eff = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign w_rows_eff = (r_rows == 7'd0) ? 7'd1 : r_rows;

    // Cursor advance tests, one bit wider so that the last column and row
    // at their maximum cannot wrap around.
    assign w_col_inc  = {1'b0, r_col} + 9'd1;
    assign w_row_inc  = {1'b0, r_row} + 8'd1;
    assign w_wrap     = w_col_inc >= {1'b0, w_cols_eff};
    assign w_row_over = w_row_inc >= {1'b0, w_rows_eff};

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_cols   <= tte_pkg::RST_COLS;
            r_rows   <= tte_pkg::RST_ROWS;
            r_fg     <= tte_pkg::RST_FG;
            r_bg     <= tte_pkg::RST_BG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tte_pkg::REG_ENABLE: r_enable <= i_cfg_data[0];
                tte_pkg::REG_COLS:   r_cols   <= i_cfg_data[7:0];
                tte_pkg::REG_ROWS:   r_rows   <= i_cfg_data[6:0];
                tte_pkg::REG_FG:     r_fg     <= i_cfg_data;
                tte_pkg::REG_BG:     r_bg     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The multiply-add unit sees the cell position for cell commands and the
    // area size for clear and scroll.
    always_comb begin
        w_mac_start = (r_state == S_MUL_A) || (r_state == S_MUL_B);
        if (r_state == S_MUL_A) begin
            w_mac_req.base = r_area ? '0 : LM;
            w_mac_req.a    = r_area ? w_cols_eff : r_col;
            w_mac_req.b    = GW_M;
        end else begin
            w_mac_req.base = r_area ? '0 : TM;
            w_mac_req.a    = r_area ? {1'b0, w_rows_eff} : {1'b0, r_row};
            w_mac_req.b    = GH_M;
        end
    end

    tte_mac u_mac (
        .i_clk   (i_clk),
        .i_start (w_mac_start),
        .i_req   (w_mac_req),
        .o_res   (w_mac_res)
    );

    // The second product stays in the unit's register while EMIT waits, so
    // the command is assembled from it and the first product kept here.
    always_comb begin
        w_out_item.op          = r_op;
        w_out_item.pixel_x     = r_area ? LM : r_res_a;
        w_out_item.pixel_y     = r_area ? TM : w_mac_res;
        w_out_item.rect_width  = r_area ? r_res_a : GW;
        w_out_item.rect_height = r_area ? w_mac_res : GH;
        w_out_item.glyph       = (r_op == tte_pkg::OP_GLYPH) ? r_glyph : 8'd0;
        w_out_item.fg_out      = r_fg;
        w_out_item.bg_out      = r_bg;
        w_out_item.last        = 1'b1;
        if (r_op == tte_pkg::OP_GLYPH) begin
            // A glyph is last only when it neither scrolls nor has more
            // tab spaces behind it.
            w_out_item.last = !(w_wrap && w_row_over) && (r_left == LW'(1));
        end else if (r_op == tte_pkg::OP_SCROLL) begin
            w_out_item.last = (r_left == '0);
        end
    end

    assign w_out_load = (r_state == S_EMIT) && w_out_free;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_phase = r_phase;
        n_op    = r_op;
        n_area  = r_area;
        n_glyph = r_glyph;
        n_left  = r_left;
        n_res_a = r_res_a;
        case (r_state)
            S_IDLE: begin
                if (w_accept && r_enable) begin
                    if (i_in_data.command) begin
                        n_op    = tte_pkg::OP_FILL;
                        n_area  = 1'b1;
                        n_left  = '0;
                        n_state = S_MUL_A;
                    end else begin
                        case (i_in_data.char_code)
                            tte_pkg::CH_NL: begin
                                n_col   = 8'd0;
                                n_phase = '0;
                                if (w_row_over) begin
                                    n_row   = w_rows_eff - 7'd1;
                                    n_op    = tte_pkg::OP_SCROLL;
                                    n_area  = 1'b1;
                                    n_left  = '0;
                                    n_state = S_MUL_A;
                                end else begin
                                    n_row = w_row_inc[6:0];
                                end
                            end
                            tte_pkg::CH_CR: begin
                                n_col   = 8'd0;
                                n_phase = '0;
                            end
                            tte_pkg::CH_TAB: begin
                                n_op    = tte_pkg::OP_GLYPH;
                                n_area  = 1'b0;
                                n_glyph = tte_pkg::CH_SPACE;
                                n_left  = TAB_COUNT - LW'(r_phase);
                                n_state = S_MUL_A;
                            end
                            tte_pkg::CH_BS: begin
                                // Backspace at column zero does nothing.
                                if (r_col != 8'd0) begin
                                    n_col   = r_col - 8'd1;
                                    n_phase = (r_phase == '0) ? PHASE_LAST
                                                              : r_phase - PW'(1);
                                    n_op    = tte_pkg::OP_FILL;
                                    n_area  = 1'b0;
                                    n_left  = '0;
                                    n_state = S_MUL_A;
                                end
                            end
                            default: begin
                                n_op    = tte_pkg::OP_GLYPH;
                                n_area  = 1'b0;
                                n_glyph = i_in_data.char_code;
                                n_left  = LW'(1);
                                n_state = S_MUL_A;
                            end
                        endcase
                    end
                end
            end
            S_MUL_A: begin
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_res_a = w_mac_res;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    case (r_op)
                        tte_pkg::OP_GLYPH: begin
                            n_left = r_left - LW'(1);
                            if (w_wrap) begin
                                n_col   = 8'd0;
                                n_phase = '0;
                                if (w_row_over) begin
                                    // Scroll before any further tab space.
                                    n_row   = w_rows_eff - 7'd1;
                                    n_op    = tte_pkg::OP_SCROLL;
                                    n_area  = 1'b1;
                                    n_state = S_MUL_A;
                                end else begin
                                    n_row = w_row_inc[6:0];
                                end
                            end else begin
                                n_col   = w_col_inc[7:0];
                                n_phase = (r_phase == PHASE_LAST) ? '0
                                                                  : r_phase + PW'(1);
                            end
                            if (!(w_wrap && w_row_over) && (r_left != LW'(1))) begin
                                n_state = S_MUL_A;
                            end
                        end
                        tte_pkg::OP_SCROLL: begin
                            // Remaining tab spaces resume on the new row.
                            if (r_left != '0) begin
                                n_op    = tte_pkg::OP_GLYPH;
                                n_area  = 1'b0;
                                n_state = S_MUL_A;
                            end
                        end
                        tte_pkg::OP_FILL: begin
                            // A whole-area fill is a clear: home the cursor.
                            if (r_area) begin
                                n_col   = 8'd0;
                                n_row   = 7'd0;
                                n_phase = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= 8'd0;
            r_row   <= 7'd0;
            r_phase <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_area  <= n_area;
        r_glyph <= n_glyph;
        r_res_a <= n_res_a;
    end

    tte_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_data  (w_out_item),
        .i_ready (i_out_ready),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // The tab phase must stay a valid column residue.
    `ASSERT_IMPL(a_phase_range, i_clk, i_rst_n, 1'b1, (int'(r_phase) < TAB_STOP), "tab phase out of range")

    // A request taken while disabled starts no work.
    `ASSERT_NEXT(a_disabled_idle, i_clk, i_rst_n, (w_accept && !r_enable), (r_state == S_IDLE), "disabled request started work")

    // Fills and scrolls carry no glyph.
    `ASSERT_IMPL(a_glyph_zero, i_clk, i_rst_n, (o_out_valid && (o_out_data.op != tte_pkg::OP_GLYPH)), (o_out_data.glyph == 8'd0), "non-glyph command carries a glyph")

endmodule
